// ===== rtl/gnms_pkg.sv =====
// Types and constants shared by the greedy non-max suppression block.
package gnms_pkg;

  localparam int unsigned CoordW  = 16;
  localparam int unsigned ScoreW  = 16;
  localparam int unsigned IndexW  = 12;
  localparam int unsigned SlotW   = 6;
  localparam int unsigned LimitW  = 16;
  localparam int unsigned InDataW = 96;
  localparam int unsigned OutDataW = 104;

  // Register map of the configuration port
  localparam logic CFG_IOU_LIMIT   = 1'b0;
  localparam logic CFG_SCORE_LIMIT = 1'b1;

  localparam logic [LimitW-1:0] IOU_LIMIT_RESET   = 16'd32768;
  localparam logic [LimitW-1:0] SCORE_LIMIT_RESET = 16'd0;

  typedef struct packed {
    logic [CoordW-1:0] top;
    logic [CoordW-1:0] left;
    logic [CoordW-1:0] bottom;
    logic [CoordW-1:0] right;
  } box_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_PUSH = 3'b100
  } state_t;

endpackage

// ===== rtl/greedy_non_max_suppression.sv =====
// Greedy non-max suppression: kept-box memory with a pipelined IoU compare.
// A box that passes the score and list-full tests is read against the N kept boxes, one
// per cycle, through a five-stage IoU pipeline: a kept item is presented once the scan
// drains and any m_tready stall clears, and s_tready returns in that cycle; a suppressed
// item frees the input when the scan drains, a skipped or dropped one at once.
// Reset empties the kept list and loads the thresholds; the memory itself is not cleared.
module greedy_non_max_suppression #(
  parameter int unsigned MAX_KEEP = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write port
  input  logic                            cfg_write,
  input  logic                            cfg_index,
  input  logic [gnms_pkg::LimitW-1:0]     cfg_data,
  // Input boxes
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // tdata: box_index, top_edge, left_edge, bottom_edge, right_edge, box_score, zero pad
  input  logic [gnms_pkg::InDataW-1:0]    s_tdata,
  // tuser: frame_start
  input  logic                            s_tuser,
  // Kept boxes
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // tdata: kept_index, kept_slot, out_top, out_left, out_bottom, out_right,
  //        out_score, zero pad
  output logic [gnms_pkg::OutDataW-1:0]   m_tdata
);
  import gnms_pkg::*;

  localparam int unsigned CW = $clog2(MAX_KEEP + 1);
  localparam int unsigned AW = (MAX_KEEP > 1) ? $clog2(MAX_KEEP) : 1;

  state_t state;

  logic [LimitW-1:0] iou_limit;
  logic [LimitW-1:0] score_limit;
  logic [CW-1:0]     count;
  logic [CW-1:0]     rd_ptr;
  logic              hit;

  box_t              kept_mem [MAX_KEEP];
  box_t              rd_data;

  box_t              cand;
  logic [IndexW-1:0] cand_index;
  logic [ScoreW-1:0] cand_score;
  logic signed [33:0] cand_area;

  // Output register
  logic [IndexW-1:0] out_index;
  logic [SlotW-1:0]  out_slot;
  box_t              out_box;
  logic [ScoreW-1:0] out_score;

  // Compare pipeline
  logic              v1, v2, v3, v4, v5;
  logic [CoordW-1:0] s2_dx, s2_dy;
  logic signed [16:0] s2_kh, s2_kw;
  logic              s2_disj;
  logic [31:0]       s3_inter;
  logic signed [33:0] s3_area;
  logic              s3_disj;
  logic signed [35:0] s4_uni;
  logic [31:0]       s4_inter;
  logic              s4_disj;
  logic [48:0]       s5_prod;
  logic [31:0]       s5_inter;
  logic              s5_disj;
  logic              s5_neg;
  logic              s5_zero;

  // Input unpacking
  logic [IndexW-1:0] in_index;
  box_t              in_box;
  logic [ScoreW-1:0] in_score;
  logic [CW-1:0]     count_eff;
  logic              in_fire;
  logic              in_pass;
  logic              issue;
  logic              scan_done;
  logic              push_fire;

  // Stage 1 signals
  logic [CoordW-1:0] y0, x0, y1, x1;
  logic              disj1;
  logic signed [16:0] cand_h, cand_w;
  logic              overlap5;

  assign in_index      = s_tdata[11:0];
  assign in_box.top    = s_tdata[27:12];
  assign in_box.left   = s_tdata[43:28];
  assign in_box.bottom = s_tdata[59:44];
  assign in_box.right  = s_tdata[75:60];
  assign in_score      = s_tdata[91:76];

  assign s_tready  = (state == ST_IDLE);
  assign in_fire   = s_tvalid && s_tready;
  assign count_eff = s_tuser ? '0 : count;
  assign in_pass   = (in_score >= score_limit) && (count_eff < CW'(MAX_KEEP));
  assign issue     = (state == ST_SCAN) && (rd_ptr != count);
  assign scan_done = (rd_ptr == count) && !(v1 || v2 || v3 || v4 || v5);
  assign push_fire = (state == ST_PUSH) && (!m_tvalid || m_tready);

  // Intersection corners of the kept box on the read port and the candidate
  always_comb begin
    y0 = (rd_data.top > cand.top) ? rd_data.top : cand.top;
    x0 = (rd_data.left > cand.left) ? rd_data.left : cand.left;
    y1 = (rd_data.bottom < cand.bottom) ? rd_data.bottom : cand.bottom;
    x1 = (rd_data.right < cand.right) ? rd_data.right : cand.right;
    disj1 = (x1 < x0) || (y1 < y0);
  end

  assign cand_h = $signed({1'b0, cand.bottom}) - $signed({1'b0, cand.top});
  assign cand_w = $signed({1'b0, cand.right}) - $signed({1'b0, cand.left});

  // Empty union only overlaps with a positive intersection; negative union never does
  assign overlap5 = !s5_disj && !s5_neg &&
                    (s5_zero ? (s5_inter != 32'd0) : ({1'b0, s5_inter, 16'b0} > s5_prod));

  // Kept-box memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (push_fire) begin
      kept_mem[count[AW-1:0]] <= cand;
    end
    if (issue) begin
      rd_data <= kept_mem[rd_ptr[AW-1:0]];
    end
  end

  // Compare pipeline payload
  always_ff @(posedge clk) begin
    cand_area <= 34'(cand_h) * 34'(cand_w);

    s2_dx   <= x1 - x0;
    s2_dy   <= y1 - y0;
    s2_kh   <= $signed({1'b0, rd_data.bottom}) - $signed({1'b0, rd_data.top});
    s2_kw   <= $signed({1'b0, rd_data.right}) - $signed({1'b0, rd_data.left});
    s2_disj <= disj1;

    s3_inter <= 32'(s2_dx) * 32'(s2_dy);
    s3_area  <= 34'(s2_kh) * 34'(s2_kw);
    s3_disj  <= s2_disj;

    s4_uni   <= 36'(s3_area) + 36'(cand_area) - $signed({4'b0, s3_inter});
    s4_inter <= s3_inter;
    s4_disj  <= s3_disj;

    s5_prod  <= 49'(iou_limit) * 49'(s4_uni[32:0]);
    s5_neg   <= s4_uni[35];
    s5_zero  <= (s4_uni == 36'sd0);
    s5_inter <= s4_inter;
    s5_disj  <= s4_disj;
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      iou_limit   <= IOU_LIMIT_RESET;
      score_limit <= SCORE_LIMIT_RESET;
      count       <= '0;
      rd_ptr      <= '0;
      hit         <= 1'b0;
      m_tvalid    <= 1'b0;
      v1          <= 1'b0;
      v2          <= 1'b0;
      v3          <= 1'b0;
      v4          <= 1'b0;
      v5          <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_IOU_LIMIT:   iou_limit   <= cfg_data;
          CFG_SCORE_LIMIT: score_limit <= cfg_data;
          default: ;
        endcase
      end

      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;

      if (push_fire) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_fire) begin
            count <= count_eff;
            if (in_pass) begin
              cand       <= in_box;
              cand_index <= in_index;
              cand_score <= in_score;
              rd_ptr     <= '0;
              hit        <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (issue) begin
            rd_ptr <= rd_ptr + CW'(1);
          end
          if (v5 && overlap5) begin
            hit <= 1'b1;
          end
          // Drop a suppressed box, else hand it to the output
          if (scan_done) begin
            state <= hit ? ST_IDLE : ST_PUSH;
          end
        end
        ST_PUSH: begin
          if (push_fire) begin
            out_index <= cand_index;
            out_slot  <= SlotW'(count);
            out_box   <= cand;
            out_score <= cand_score;
            count     <= count + CW'(1);
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_tdata = {6'b0, out_score, out_box.right, out_box.bottom, out_box.left,
                    out_box.top, out_slot, out_index};

endmodule
